// ===== design/c2pd_pkg.sv =====
// Shared types, constants and helpers of the capnography packet decoder.
// Used by c2pd_parse, c2pd_conv and co2_sensor_packet_decoder_core.
package c2pd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;
  localparam int BODY_DEPTH    = 6;
  localparam int BODY_AW       = $clog2(BODY_DEPTH);
  localparam int MANT_W        = 24;
  localparam int COEF_W        = 25;
  localparam int PROD_W        = 32 + COEF_W;

  localparam logic [7:0] TYPE_WAVE_UC = 8'h57;
  localparam logic [7:0] TYPE_WAVE_LC = 8'h77;
  localparam logic [7:0] TYPE_PARAM   = 8'h50;
  localparam logic [7:0] TYPE_STATUS  = 8'h53;
  localparam logic [7:0] SEL_RESP     = 8'h30;
  localparam logic [7:0] SEL_INSP     = 8'h31;
  localparam logic [7:0] SEL_ETCO2    = 8'h32;
  localparam logic [7:0] CHK_XOR      = 8'hF0;
  localparam logic [7:0] PUMP_OFF_BIT = 8'h02;
  localparam logic [7:0] OCCL_BIT     = 8'h02;
  localparam logic [7:0] RUN_BIT      = 8'h40;

  localparam logic [3:0] LEN_WAVE   = 4'd10;
  localparam logic [3:0] LEN_PARAM  = 4'd8;
  localparam logic [3:0] LEN_STATUS = 4'd6;
  localparam logic [3:0] LEN_NONE   = 4'd0;
  localparam logic [3:0] POS_MAX    = 4'd9;
  localparam logic [3:0] POS_PSUM   = 4'd3;

  localparam logic [COEF_W-1:0] COEF_WAVE  = 25'd2231370;
  localparam logic [COEF_W-1:0] COEF_CO2   = 25'd22313697;
  localparam logic [COEF_W-1:0] COEF_UNITY = 25'h1000000;

  localparam logic [31:0] LIM_NEG = 32'h8000_0000;
  localparam logic [31:0] LIM_POS = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    KIND_WAVE   = 3'd0,
    KIND_RESP   = 3'd1,
    KIND_INSP   = 3'd2,
    KIND_ETCO2  = 3'd3,
    KIND_STATUS = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNIT_CODE   = 2'd0,
    CFG_ALT_VARIANT = 2'd1,
    CFG_MODULE_EN   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] word;
    logic        occluded;
  } item_t;

  function automatic logic [3:0] frame_len(input logic [7:0] t);
    logic [3:0] len;
    len = LEN_NONE;
    if (t == TYPE_WAVE_UC || t == TYPE_WAVE_LC) len = LEN_WAVE;
    else if (t == TYPE_PARAM) len = LEN_PARAM;
    else if (t == TYPE_STATUS) len = LEN_STATUS;
    return len;
  endfunction

endpackage

// ===== design/c2pd_parse.sv =====
// Packet framing: type byte, body capture, byte sum, checksum and occlusion flag.
// Emits one decoded item per good packet, none for an unknown parameter selector. Depends on c2pd_pkg.
module c2pd_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       in_rx_byte,
  input  logic             in_packet_start,
  input  logic             item_ready,
  input  logic             alt_variant,
  input  logic             module_en,
  output logic             item_valid,
  output c2pd_pkg::item_t  item
);
  import c2pd_pkg::*;

  logic [7:0]   type_r, type_nxt;
  logic [7:0]   sum_r, sum_nxt;
  logic [3:0]   idx_r, idx_nxt;
  logic         occ_r, occ_nxt;
  logic [7:0]   body_r [BODY_DEPTH];
  logic         wr_en;
  logic [BODY_AW-1:0] wr_addr;
  logic         emit;
  item_t        item_nxt;
  logic         item_v_r;
  item_t        item_r;
  logic         in_fire;
  logic [3:0]   len;
  logic         occ_calc;

  assign in_fire = in_valid && item_ready;
  assign len     = frame_len(type_r);
  assign wr_addr = BODY_AW'(idx_r - 4'd1);

  assign occ_calc = module_en && ((body_r[1] & OCCL_BIT) != 8'h00) &&
                    ((body_r[3] & RUN_BIT) != 8'h00) &&
                    (alt_variant || ((body_r[0] & PUMP_OFF_BIT) == 8'h00));

  always_comb begin
    type_nxt = type_r;
    sum_nxt  = sum_r;
    idx_nxt  = idx_r;
    occ_nxt  = occ_r;
    wr_en    = 1'b0;
    emit     = 1'b0;
    item_nxt.kind     = KIND_WAVE;
    item_nxt.word     = {body_r[0], body_r[1], body_r[2], body_r[3]};
    item_nxt.occluded = occ_r;
    if (in_fire) begin
      if (in_packet_start) begin
        type_nxt = in_rx_byte;
        sum_nxt  = 8'h00;
        idx_nxt  = (frame_len(in_rx_byte) != LEN_NONE) ? 4'd1 : 4'd0;
      end else if (idx_r != 4'd0) begin
        if (len == LEN_NONE || idx_r >= len || idx_r > POS_MAX) begin
          idx_nxt = 4'd0;
        end else begin
          wr_en = (idx_r <= 4'(BODY_DEPTH));
          if (idx_r < len - 4'd1) begin
            if (type_r != TYPE_PARAM || idx_r >= POS_PSUM) begin
              sum_nxt = sum_r + in_rx_byte;
            end
            idx_nxt = idx_r + 4'd1;
          end else begin
            idx_nxt = 4'd0;
            if ((sum_r ^ CHK_XOR) == in_rx_byte) begin
              priority if (type_r == TYPE_STATUS) begin
                occ_nxt           = occ_calc;
                emit              = 1'b1;
                item_nxt.kind     = KIND_STATUS;
                item_nxt.word     = 32'h0;
                item_nxt.occluded = occ_calc;
              end else if (type_r == TYPE_PARAM) begin
                item_nxt.word = {body_r[2], body_r[3], body_r[4], body_r[5]};
                emit          = 1'b1;
                priority if (body_r[1] == SEL_RESP) item_nxt.kind = KIND_RESP;
                else if (body_r[1] == SEL_INSP) item_nxt.kind = KIND_INSP;
                else if (body_r[1] == SEL_ETCO2) item_nxt.kind = KIND_ETCO2;
                else emit = 1'b0;
              end else begin
                emit = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r   <= 8'h00;
      sum_r    <= 8'h00;
      idx_r    <= 4'd0;
      occ_r    <= 1'b0;
      item_v_r <= 1'b0;
    end else begin
      type_r <= type_nxt;
      sum_r  <= sum_nxt;
      idx_r  <= idx_nxt;
      occ_r  <= occ_nxt;
      if (item_ready) begin
        item_v_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      body_r[wr_addr] <= in_rx_byte;
    end
    if (emit) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = item_v_r;
  assign item       = item_r;

endmodule

// ===== design/c2pd_conv.sv =====
// Float-to-fixed pipeline: shift and clamp, coefficient multiply, round and clamp.
// Three registered stages, the last one is the result register. Depends on c2pd_pkg.
module c2pd_conv #(
  parameter int FRAC_BITS = c2pd_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  c2pd_pkg::item_t  item,
  input  logic [1:0]       unit_code,
  input  logic             out_ready,
  output logic             item_ready,
  output logic             out_valid,
  output logic [2:0]       out_result_kind,
  output logic [31:0]      out_value,
  output logic [31:0]      out_value_mmhg,
  output logic             out_occluded,
  output logic             out_saturated
);
  import c2pd_pkg::*;

  localparam int SHIFT_BIAS = 64 + MANT_W - FRAC_BITS;

  // shift stage
  logic              b_v_r;
  kind_t             b_kind_r;
  logic              b_neg_r, b_sat_r, b_occ_r;
  logic [31:0]       b_mag_r;
  // multiply stage
  logic              c_v_r;
  kind_t             c_kind_r;
  logic              c_neg_r, c_sat_r, c_occ_r;
  logic [31:0]       c_mag_r;
  logic [PROD_W-1:0] c_prod_r;
  // result stage
  logic              d_v_r;
  kind_t             d_kind_r;
  logic [31:0]       d_value_r, d_mmhg_r;
  logic              d_occ_r, d_sat_r;

  logic rd_b, rd_c, rd_d;

  logic [MANT_W-1:0] mant;
  logic [6:0]        expo;
  logic              sgn;
  logic signed [8:0] sh, nsh;
  logic [31:0]       lim_b;
  logic [55:0]       wide;
  logic [31:0]       mag_nxt;
  logic              sat_nxt;

  logic [COEF_W-1:0] coef;

  logic [PROD_W-1:0] rnd;
  logic [32:0]       scaled;
  logic [31:0]       lim_d, smag;
  logic              ssat;

  assign rd_d       = !d_v_r || out_ready;
  assign rd_c       = !c_v_r || rd_d;
  assign rd_b       = !b_v_r || rd_c;
  assign item_ready = rd_b;

  assign mant  = item.word[31:8];
  assign expo  = item.word[6:0];
  assign sgn   = item.word[7];
  assign sh    = $signed({2'b00, expo}) - 9'(SHIFT_BIAS);
  assign nsh   = -sh;
  assign lim_b = sgn ? LIM_NEG : LIM_POS;
  assign wide  = {32'h0, mant} << sh[4:0];

  always_comb begin
    mag_nxt = 32'h0;
    sat_nxt = 1'b0;
    priority if (mant == '0 || sh <= -9'sd25) begin
      mag_nxt = 32'h0;
    end else if (sh < 9'sd0) begin
      mag_nxt = 32'(mant >> nsh[4:0]);
    end else if (sh > 9'sd31) begin
      mag_nxt = lim_b;
      sat_nxt = 1'b1;
    end else if (wide > {24'h0, lim_b}) begin
      mag_nxt = lim_b;
      sat_nxt = 1'b1;
    end else begin
      mag_nxt = wide[31:0];
    end
  end

  always_comb begin
    coef = COEF_UNITY;
    if (!unit_code[0]) begin
      unique case (b_kind_r)
        KIND_WAVE:             coef = COEF_WAVE;
        KIND_INSP, KIND_ETCO2: coef = COEF_CO2;
        default:               coef = COEF_UNITY;
      endcase
    end
  end

  assign rnd    = c_prod_r + (PROD_W'(1) << (MANT_W - 1));
  assign scaled = rnd[PROD_W-1:MANT_W];
  assign lim_d  = c_neg_r ? LIM_NEG : LIM_POS;
  assign ssat   = scaled > {1'b0, lim_d};
  assign smag   = ssat ? lim_d : scaled[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      if (rd_b) b_v_r <= item_valid;
      if (rd_c) c_v_r <= b_v_r;
      if (rd_d) d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_b && item_valid) begin
      b_kind_r <= item.kind;
      b_neg_r  <= sgn;
      b_mag_r  <= mag_nxt;
      b_sat_r  <= sat_nxt;
      b_occ_r  <= item.occluded;
    end
    if (rd_c && b_v_r) begin
      c_kind_r <= b_kind_r;
      c_neg_r  <= b_neg_r;
      c_mag_r  <= b_mag_r;
      c_sat_r  <= b_sat_r;
      c_occ_r  <= b_occ_r;
      c_prod_r <= PROD_W'(b_mag_r) * PROD_W'(coef);
    end
    if (rd_d && c_v_r) begin
      d_kind_r  <= c_kind_r;
      d_value_r <= c_neg_r ? (32'h0 - smag) : smag;
      d_mmhg_r  <= c_neg_r ? (32'h0 - c_mag_r) : c_mag_r;
      d_occ_r   <= c_occ_r;
      d_sat_r   <= c_sat_r || ssat;
    end
  end

  assign out_valid       = d_v_r;
  assign out_result_kind = d_kind_r;
  assign out_value       = d_value_r;
  assign out_value_mmhg  = d_mmhg_r;
  assign out_occluded    = d_occ_r;
  assign out_saturated   = d_sat_r;

endmodule

// ===== design/co2_sensor_packet_decoder_core.sv =====
// Capnography packet decoder top level: configuration registers, framing, conversion.
// Instantiates c2pd_parse and c2pd_conv; depends on c2pd_pkg.
//
// Accepts one packet byte per cycle, every cycle, as long as the result side
// drains. The last byte of a good wave, status or parameter packet with a known
// selector yields one result, which passes through the item register, shift
// stage, multiply stage and result register to the result port. The 32x25
// coefficient multiply in its own stage sets the clock rate. Backpressure from
// out_ready reaches in_ready only once the shift, multiply and result stages all
// hold results. Registers: 0 unit code, 1 variant occlusion rule,
// 2 module enable; write them only while no packet is in flight.
module co2_sensor_packet_decoder_core #(
  parameter int FRAC_BITS = c2pd_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  input  logic                            in_packet_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_result_kind,
  output logic [31:0]                     out_value,
  output logic [31:0]                     out_value_mmhg,
  output logic                            out_occluded,
  output logic                            out_saturated,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [c2pd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [c2pd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import c2pd_pkg::*;

  logic [1:0] unit_code_r;
  logic       alt_variant_r;
  logic       module_en_r;
  logic       item_valid;
  logic       item_ready;
  item_t      item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_code_r   <= 2'd0;
      alt_variant_r <= 1'b0;
      module_en_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_UNIT_CODE:   unit_code_r   <= cfg_data[1:0];
        CFG_ALT_VARIANT: alt_variant_r <= cfg_data[0];
        CFG_MODULE_EN:   module_en_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  c2pd_parse u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_rx_byte      (in_rx_byte),
    .in_packet_start (in_packet_start),
    .item_ready      (item_ready),
    .alt_variant     (alt_variant_r),
    .module_en       (module_en_r),
    .item_valid      (item_valid),
    .item            (item)
  );

  c2pd_conv #(
    .FRAC_BITS (FRAC_BITS)
  ) u_conv (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item_valid),
    .item            (item),
    .unit_code       (unit_code_r),
    .out_ready       (out_ready),
    .item_ready      (item_ready),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_value       (out_value),
    .out_value_mmhg  (out_value_mmhg),
    .out_occluded    (out_occluded),
    .out_saturated   (out_saturated)
  );

  assign in_ready = item_ready;

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_STATUS |->
      out_value == 32'h0 && out_value_mmhg == 32'h0 && !out_saturated)
    else $error("status transaction carries a nonzero value");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the result side drains");

  a_resp_unscaled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_RESP |-> out_value == out_value_mmhg)
    else $error("respiration rate was scaled");

  a_occl_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_STATUS && !module_en_r |-> !out_occluded)
    else $error("occlusion reported with module disabled");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for co2_sensor_packet_decoder_core: drives capnography packet byte streams,
// predicts each decoded reading and checks every result transaction field by field.
// Depends on c2pd_pkg and the decoder RTL only.
module testbench;

  localparam int FRAC         = c2pd_pkg::FRAC_BITS_DEF;
  localparam int EXP_BIAS     = 88 - FRAC;
  localparam int IDLE_PCT     = 36;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;

  localparam logic [7:0] PKT_WAVE    = 8'h57;
  localparam logic [7:0] PKT_WAVE_LC = 8'h77;
  localparam logic [7:0] PKT_PARAM   = 8'h50;
  localparam logic [7:0] PKT_STATUS  = 8'h53;
  localparam logic [7:0] PKT_UNUSED  = 8'h55;
  localparam logic [7:0] SEL_RR      = 8'h30;
  localparam logic [7:0] SEL_FICO2   = 8'h31;
  localparam logic [7:0] SEL_ETCO2   = 8'h32;
  localparam logic [7:0] SEL_BOGUS   = 8'h33;
  localparam logic [7:0] SUM_MASK    = 8'hF0;
  localparam logic [7:0] PUMP_OFF    = 8'h02;
  localparam logic [7:0] OCCLUSION   = 8'h02;
  localparam logic [7:0] PUMP_RUN    = 8'h40;

  localparam logic [63:0] SCALE_WAVE = 64'd2231370;
  localparam logic [63:0] SCALE_CO2  = 64'd22313697;
  localparam logic [63:0] ROUND_HALF = 64'h80_0000;
  localparam logic [63:0] MAG_NEG    = 64'h8000_0000;
  localparam logic [63:0] MAG_POS    = 64'h7FFF_FFFF;

  typedef struct packed {
    c2pd_pkg::kind_t kind;
    logic [31:0]     value;
    logic [31:0]     mmhg;
    logic            occluded;
    logic            saturated;
  } reading_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
    logic        sat;
  } fixed_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte      = 8'h00;
  logic        in_packet_start = 1'b0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [2:0]  out_result_kind;
  logic [31:0] out_value;
  logic [31:0] out_value_mmhg;
  logic        out_occluded;
  logic        out_saturated;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic [c2pd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [c2pd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic        gaps_on = 1'b1;
  int          mismatches;
  int          idle_cycles;
  int          packet_bytes;
  int          readings_checked;
  int          readings_saturated;
  int          status_checked;
  int          bad_checksums;
  int          settings_used;

  logic [7:0]  pkt_type;
  logic [7:0]  body [9];
  logic [3:0]  byte_pos;
  logic [7:0]  chk_sum;
  logic        occ_flag;
  logic [1:0]  unit_code;
  logic        alt_rule;
  logic        module_en;
  reading_t    pending_readings [$];
  reading_t    oldest;

  co2_sensor_packet_decoder_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .in_packet_start (in_packet_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_value       (out_value),
    .out_value_mmhg  (out_value_mmhg),
    .out_occluded    (out_occluded),
    .out_saturated   (out_saturated),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= gaps_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  function automatic logic [3:0] packet_length(input logic [7:0] t);
    if (t == PKT_WAVE || t == PKT_WAVE_LC) return 4'd10;
    if (t == PKT_PARAM) return 4'd8;
    if (t == PKT_STATUS) return 4'd6;
    return 4'd0;
  endfunction

  function automatic fixed_t float_to_fixed(input logic [31:0] w);
    fixed_t      r;
    logic [23:0] m;
    int          s;
    logic [63:0] lim;
    m     = w[31:8];
    s     = int'(w[6:0]) - 88 + FRAC;
    r.neg = w[7];
    r.sat = 1'b0;
    lim   = r.neg ? MAG_NEG : MAG_POS;
    if (m == 0 || s <= -25) r.mag = 64'd0;
    else if (s < 0) r.mag = 64'(m >> (-s));
    else if (s > 31) r.mag = lim + 64'd1;
    else r.mag = 64'(m) << s;
    if (r.mag > lim) begin
      r.mag = lim;
      r.sat = 1'b1;
    end
    return r;
  endfunction

  function automatic fixed_t apply_scale(input fixed_t v, input logic [63:0] coef);
    logic [63:0] lim;
    lim   = v.neg ? MAG_NEG : MAG_POS;
    v.mag = (v.mag * coef + ROUND_HALF) >> 24;
    if (v.mag > lim) begin
      v.mag = lim;
      v.sat = 1'b1;
    end
    return v;
  endfunction

  function automatic logic [31:0] to_word(input fixed_t v);
    return v.neg ? (32'd0 - v.mag[31:0]) : v.mag[31:0];
  endfunction

  task automatic clear_decoder_state();
    pkt_type  = 8'h00;
    byte_pos  = 4'd0;
    chk_sum   = 8'h00;
    occ_flag  = 1'b0;
    unit_code = 2'd0;
    alt_rule  = 1'b0;
    module_en = 1'b0;
    for (int i = 0; i < 9; i++) body[i] = 8'h00;
  endtask

  // advance the decoder state by one accepted byte; queue any reading it yields
  task automatic take_byte(input logic [7:0] b, input logic st);
    logic [3:0]      len;
    logic [3:0]      pos;
    logic            found;
    c2pd_pkg::kind_t kind;
    fixed_t          raw;
    fixed_t          scaled;
    reading_t        r;
    found = 1'b0;
    if (st || byte_pos != 0) packet_bytes++;
    if (st) begin
      pkt_type = b;
      chk_sum  = 8'h00;
      byte_pos = (packet_length(b) != 0) ? 4'd1 : 4'd0;
    end else if (byte_pos != 0) begin
      len = packet_length(pkt_type);
      pos = byte_pos;
      if (len == 0 || pos >= len) begin
        byte_pos = 4'd0;
      end else begin
        body[pos - 1] = b;
        if (pos < len - 1) begin
          if (pkt_type != PKT_PARAM || pos >= 3) chk_sum = chk_sum + b;
          byte_pos = pos + 4'd1;
        end else begin
          byte_pos = 4'd0;
          if ((chk_sum ^ SUM_MASK) != b) begin
            bad_checksums++;
          end else if (pkt_type == PKT_STATUS) begin
            occ_flag = module_en && (body[1] & OCCLUSION) != 0 && (body[3] & PUMP_RUN) != 0
                       && (alt_rule || (body[0] & PUMP_OFF) == 0);
            r     = '{c2pd_pkg::KIND_STATUS, 32'd0, 32'd0, occ_flag, 1'b0};
            found = 1'b1;
          end else begin
            found = 1'b1;
            if (pkt_type == PKT_PARAM) begin
              if (body[1] == SEL_RR) kind = c2pd_pkg::KIND_RESP;
              else if (body[1] == SEL_FICO2) kind = c2pd_pkg::KIND_INSP;
              else if (body[1] == SEL_ETCO2) kind = c2pd_pkg::KIND_ETCO2;
              else found = 1'b0;
              raw    = float_to_fixed({body[2], body[3], body[4], body[5]});
              scaled = (kind != c2pd_pkg::KIND_RESP && !unit_code[0]) ?
                       apply_scale(raw, SCALE_CO2) : raw;
            end else begin
              kind   = c2pd_pkg::KIND_WAVE;
              raw    = float_to_fixed({body[0], body[1], body[2], body[3]});
              scaled = !unit_code[0] ? apply_scale(raw, SCALE_WAVE) : raw;
            end
            r = '{kind, to_word(scaled), to_word(raw), occ_flag, raw.sat | scaled.sat};
          end
        end
      end
    end
    if (found) pending_readings.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d value %h",
                                  out_result_kind, out_value));
      end else begin
        oldest = pending_readings.pop_front();
        readings_checked++;
        if (oldest.saturated) readings_saturated++;
        if (oldest.kind == c2pd_pkg::KIND_STATUS) status_checked++;
        if (out_result_kind !== oldest.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_result_kind, oldest.kind));
        if (out_value !== oldest.value)
          report_mismatch($sformatf("value %h, want %h", out_value, oldest.value));
        if (out_value_mmhg !== oldest.mmhg)
          report_mismatch($sformatf("value_mmhg %h, want %h", out_value_mmhg, oldest.mmhg));
        if (out_occluded !== oldest.occluded)
          report_mismatch($sformatf("occluded %b, want %b", out_occluded, oldest.occluded));
        if (out_saturated !== oldest.saturated)
          report_mismatch($sformatf("saturated %b, want %b", out_saturated, oldest.saturated));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: stalled for %0d cycles, %0d readings outstanding",
                 idle_cycles, pending_readings.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic st);
    @(negedge clk);
    if (gaps_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid        = 1'b1;
    in_rx_byte      = b;
    in_packet_start = st;
    do @(posedge clk); while (!in_ready);
    take_byte(b, st);
  endtask

  // data holds body positions 1..8, position 1 in the top byte
  task automatic send_frame(input logic [7:0] t, input logic [63:0] data,
                            input logic corrupt);
    logic [7:0] sum;
    logic [7:0] flip;
    int         n;
    n    = packet_length(t) - 2;
    sum  = 8'h00;
    flip = corrupt ? 8'($urandom_range(255, 1)) : 8'h00;
    send_byte(t, 1'b1);
    for (int i = 0; i < n; i++) begin
      send_byte(data[63 - 8 * i -: 8], 1'b0);
      if (t != PKT_PARAM || i >= 2) sum = sum + data[63 - 8 * i -: 8];
    end
    send_byte(sum ^ SUM_MASK ^ flip, 1'b0);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input c2pd_pkg::cfg_idx_t idx, input logic [7:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      c2pd_pkg::CFG_UNIT_CODE:   unit_code = d[1:0];
      c2pd_pkg::CFG_ALT_VARIANT: alt_rule  = d[0];
      c2pd_pkg::CFG_MODULE_EN:   module_en = d[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] make_word();
    logic [23:0] m;
    logic [6:0]  e;
    int          c;
    c = $urandom_range(9);
    if (c == 0) m = 24'h000000;
    else if (c == 1) m = 24'hFFFFFF;
    else if (c == 2) m = 24'h000001;
    else m = 24'($urandom);
    c = $urandom_range(9);
    if (c < 2) begin
      e = 7'($urandom);
    end else if (c == 2) begin
      case ($urandom_range(5))
        0: e = 7'd0;
        1: e = 7'(EXP_BIAS - 25);
        2: e = 7'(EXP_BIAS - 24);
        3: e = 7'(EXP_BIAS + 31);
        4: e = 7'(EXP_BIAS + 32);
        default: e = 7'h7F;
      endcase
    end else begin
      e = 7'($urandom_range(EXP_BIAS + 31, EXP_BIAS - 24));
    end
    return {m, 1'($urandom), e};
  endfunction

  task automatic random_frame();
    logic [63:0] data;
    logic [7:0]  t;
    int          c;
    data = {$urandom, $urandom};
    c    = $urandom_range(99);
    if (c < 35) begin
      t = $urandom_range(1) ? PKT_WAVE : PKT_WAVE_LC;
      data[63:32] = make_word();
    end else if (c < 70) begin
      t = PKT_PARAM;
      case ($urandom_range(9))
        0: data[55:48] = 8'($urandom);
        1, 2, 3: data[55:48] = SEL_RR;
        4, 5, 6: data[55:48] = SEL_FICO2;
        default: data[55:48] = SEL_ETCO2;
      endcase
      data[47:16] = make_word();
    end else begin
      t = PKT_STATUS;
      if ($urandom_range(1)) data[55:48] = data[55:48] | OCCLUSION;
      if ($urandom_range(1)) data[39:32] = data[39:32] | PUMP_RUN;
    end
    send_frame(t, data, $urandom_range(99) < 8);
  endtask

  task automatic random_traffic(input int target);
    int first;
    int c;
    first = packet_bytes;
    while (packet_bytes - first < target) begin
      c = $urandom_range(99);
      if (c < 85) begin
        random_frame();
      end else if (c < 90) begin
        // cut short; the next start byte restarts framing
        case ($urandom_range(2))
          0: send_byte(PKT_WAVE, 1'b1);
          1: send_byte(PKT_PARAM, 1'b1);
          default: send_byte(PKT_STATUS, 1'b1);
        endcase
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom), 1'b0);
      end else if (c < 95) begin
        send_byte($urandom_range(1) ? PKT_UNUSED : 8'($urandom), 1'b1);
        send_byte(8'($urandom), 1'b0);
      end else begin
        send_byte(8'($urandom), 1'b0);
      end
    end
    send_byte(PKT_UNUSED, 1'b1);
  endtask

  task automatic test_special_cases();
    send_byte(8'hFF, 1'b0);
    send_byte(PKT_UNUSED, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(PKT_PARAM, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(SEL_RR, 1'b0);
    send_frame(PKT_STATUS, {8'h02, 8'h02, 8'h00, 8'h40, 32'h0}, 1'b0);
    send_frame(PKT_STATUS, {8'h00, 8'hFF, 8'h00, 8'hFF, 32'h0}, 1'b1);
    send_frame(PKT_WAVE_LC, {32'hFFFF_FF7F, 32'h0}, 1'b0);
    send_frame(PKT_PARAM, {8'h00, SEL_FICO2, 32'hFFFF_FFFF, 16'h0}, 1'b0);
    send_frame(PKT_PARAM, {8'h00, SEL_BOGUS, 32'h8000_0048, 16'h0}, 1'b0);
  endtask

  task automatic test_register_sweeps();
    logic [3:0] setting;
    logic [7:0] junk;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: setting = 4'b00_0_1;
        1: setting = 4'b01_1_1;
        2: setting = 4'b10_0_1;
        3: setting = 4'b11_1_0;
        4: setting = 4'b11_1_1;
        5: setting = 4'b00_0_0;
        default: setting = 4'($urandom);
      endcase
      settle();
      junk = 8'($urandom);
      write_reg(c2pd_pkg::CFG_UNIT_CODE, {junk[7:2], setting[3:2]});
      junk = 8'($urandom);
      write_reg(c2pd_pkg::CFG_ALT_VARIANT, {junk[7:1], setting[1]});
      junk = 8'($urandom);
      write_reg(c2pd_pkg::CFG_MODULE_EN, {junk[7:1], setting[0]});
      settings_used++;
      random_traffic(120);
    end
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    random_traffic(150);
    gaps_on = 1'b1;
  endtask

  initial begin
    clear_decoder_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_special_cases();
    test_register_sweeps();
    test_back_to_back();
    settle();

    $display("tb: %0d packet bytes, %0d readings checked (%0d saturated, %0d status)",
             packet_bytes, readings_checked, readings_saturated, status_checked);
    $display("tb: %0d bad-checksum packets dropped, %0d register settings, %0d mismatches",
             bad_checksums, settings_used, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
